### hdl/power_step_event_detector_unit_defines.svh
// Assertion macros for the power step event detector checker.
`ifndef POWER_STEP_EVENT_DETECTOR_UNIT_DEFINES_SVH
`define POWER_STEP_EVENT_DETECTOR_UNIT_DEFINES_SVH

// Clocked assertion, idle while reset is high.
`define PSED_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Clocked assertion that also holds across reset.
`define PSED_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### hdl/psed_pkg.sv
// Package of the power step event detector: constants, codes and types.
`timescale 1ns / 1ps

package psed_pkg;

   // Default sizes
   localparam int DEF_MAX_WINDOW  = 32;
   localparam int DEF_SAMPLE_BITS = 24;

   // Configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 23;
   localparam int WLEN_BITS      = 6;
   localparam int BAND_BITS      = 23;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEADY_BAND   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_STEP      = 2'd2;

   localparam logic [WLEN_BITS-1:0] RESET_WINDOW_LENGTH = 6'd4;
   localparam logic [BAND_BITS-1:0] RESET_STEADY_BAND   = 23'd320;
   localparam logic [BAND_BITS-1:0] RESET_MIN_STEP      = 23'd480;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_SCAN,
      ST_CHECK,
      ST_DIV_ACTIVE,
      ST_DIV_REACTIVE,
      ST_DECIDE,
      ST_EMIT
   } psed_state_type;

   // Divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

### hdl/power_step_event_detector_unit.sv
// Top level of the power step event detector.
//
// Usage: one request on req_ carries an active and a reactive power sample.
// The block writes it into the sample ring; with the window full it scans the
// W stored samples for spread and sums and, if the spread is within the band,
// runs both rounded means through one serial divider. A step above min_step
// yields one response on rsp_; otherwise none. Configuration writes on csr_
// to a valid index clear the window and the baseline; they belong in idle time.
// Timing: req_tready is high only between requests. A request that leaves the
// window unfilled only writes the ring; for a full window the time is set by
// the window scan through the single read port and the one-bit-per-cycle
// divider, whose dividend is SUM_BITS wide (SUM_BITS = SAMPLE_BITS +
// clog2(MAX_WINDOW+1), 30 by default). A response sits in an output register
// until taken; the block takes new requests meanwhile and stalls only when a
// second response is ready before the first is taken.
// Reset (synchronous, active high) restores the register defaults and empties
// the window and the baseline.
`timescale 1ns / 1ps

module power_step_event_detector_unit #(
   parameter int MAX_WINDOW  = psed_pkg::DEF_MAX_WINDOW,
   parameter int SAMPLE_BITS = psed_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request: active_power, reactive_power
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    req_tdata,
   // response: delta_active, delta_reactive, new_level
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((3*SAMPLE_BITS+2+7)/8)*8-1:0]  rsp_tdata,
   // response flags: turn_on
   output logic [0:0]                            rsp_tuser,
   // configuration write port
   input  logic                                  csr_we,
   input  logic [psed_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [psed_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import psed_pkg::*;

   localparam int SB    = SAMPLE_BITS;
   localparam int AW    = $clog2(MAX_WINDOW);
   localparam int CW    = $clog2(MAX_WINDOW + 1);
   localparam int SW    = SAMPLE_BITS + CW;
   localparam int ODW   = ((3*SAMPLE_BITS+2+7)/8)*8;
   localparam int CMPW  = ((SAMPLE_BITS + 1) > BAND_BITS) ? (SAMPLE_BITS + 1) : BAND_BITS;

   psed_state_type state_ff, state_in;

   logic [WLEN_BITS-1:0] wlen_ff, wlen_in;
   logic [BAND_BITS-1:0] band_ff, band_in;
   logic [BAND_BITS-1:0] mstep_ff, mstep_in;

   logic [CW-1:0]        fill_ff, fill_in;
   logic [AW-1:0]        oldest_ff, oldest_in;
   logic                 bvalid_ff, bvalid_in;
   logic [SB-1:0]        base_a_ff, base_a_in;
   logic [SB-1:0]        base_r_ff, base_r_in;

   logic [SB-1:0]        samp_a_ff, samp_a_in;
   logic [SB-1:0]        samp_r_ff, samp_r_in;

   logic [CW-1:0]        rd_idx_ff, rd_idx_in;
   logic                 rdv_ff, rdv_in;
   logic signed [SB-1:0] mn_ff, mn_in;
   logic signed [SB-1:0] mx_ff, mx_in;
   logic [SW-1:0]        sum_a_ff, sum_a_in;
   logic [SW-1:0]        sum_r_ff, sum_r_in;

   logic [SB-1:0]        lp_ff, lp_in;
   logic [SB-1:0]        lq_ff, lq_in;
   logic [SB:0]          step_ff, step_in;
   logic [SB:0]          dq_ff, dq_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SB:0]          rsp_da_ff, rsp_da_in;
   logic [SB:0]          rsp_dr_ff, rsp_dr_in;
   logic                 rsp_on_ff, rsp_on_in;
   logic [SB-1:0]        rsp_lvl_ff, rsp_lvl_in;

   // Control from the sequencer
   logic                 accept;
   logic                 mem_we;
   logic                 div_start;
   logic                 rsp_load;

   // Datapath helpers
   logic [CW-1:0]        w_eff;
   logic [CW-1:0]        w_half;
   logic                 fill_short;
   logic                 full_after;
   logic [AW-1:0]        slot;
   logic [CW-1:0]        oldest_inc;
   logic                 rd_en;
   logic [SB-1:0]        rd_active;
   logic [SB-1:0]        rd_reactive;
   logic [SB:0]          spread;
   logic                 spread_ok;
   logic [SW-1:0]        mag_a;
   logic [SW-1:0]        mag_r;
   logic [SW-1:0]        div_dividend;
   logic [SW-1:0]        div_quotient;
   div_status_type       div_status;
   logic                 mean_neg;
   logic [SB:0]          mean_mag;
   logic [SB:0]          mean_full;
   logic [SB:0]          step_c;
   logic [SB:0]          dq_c;
   logic [SB:0]          step_mag;
   logic                 step_big;

   // Effective window length: zero means one, saturate at the ring depth
   always_comb begin
      if (wlen_ff == '0) begin
         w_eff = CW'(1);
      end else if (32'(wlen_ff) > MAX_WINDOW) begin
         w_eff = CW'(MAX_WINDOW);
      end else begin
         w_eff = CW'(wlen_ff);
      end
      w_half = w_eff >> 1;
   end

   // Ring slot and fill bookkeeping
   always_comb begin
      fill_short = (fill_ff < w_eff);
      oldest_inc = CW'(oldest_ff) + CW'(1);
      slot       = fill_short ? fill_ff[AW-1:0] : oldest_ff;
      full_after = !fill_short || ((fill_ff + CW'(1)) == w_eff);
      rd_en      = (rd_idx_ff < w_eff);
   end

   // Spread check and divider operands
   always_comb begin
      spread    = {mx_ff[SB-1], mx_ff} - {mn_ff[SB-1], mn_ff};
      spread_ok = !(CMPW'(spread) > CMPW'(band_ff));
      mag_a     = (sum_a_ff[SW-1] ? (SW'(0) - sum_a_ff) : sum_a_ff)
                  + {{(SW-CW){1'b0}}, w_half};
      mag_r     = (sum_r_ff[SW-1] ? (SW'(0) - sum_r_ff) : sum_r_ff)
                  + {{(SW-CW){1'b0}}, w_half};
      div_dividend = (state_ff == ST_CHECK) ? mag_a : mag_r;
   end

   // Signed mean from the quotient magnitude
   always_comb begin
      mean_neg  = (state_ff == ST_DIV_ACTIVE) ? sum_a_ff[SW-1] : sum_r_ff[SW-1];
      mean_mag  = div_quotient[SB:0];
      mean_full = mean_neg ? ((SB+1)'(0) - mean_mag) : mean_mag;
   end

   // Step against the baseline
   always_comb begin
      step_c   = {lp_ff[SB-1], lp_ff} - {base_a_ff[SB-1], base_a_ff};
      dq_c     = {lq_ff[SB-1], lq_ff} - {base_r_ff[SB-1], base_r_ff};
      step_mag = step_c[SB] ? ((SB+1)'(0) - step_c) : step_c;
      step_big = (CMPW'(step_mag) > CMPW'(mstep_ff));
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            state_in = full_after ? ST_SCAN : ST_IDLE;
         end
         ST_SCAN: begin
            if (!rd_en && !rdv_ff) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = spread_ok ? ST_DIV_ACTIVE : ST_IDLE;
         end
         ST_DIV_ACTIVE: begin
            if (div_status.done) state_in = ST_DIV_REACTIVE;
         end
         ST_DIV_REACTIVE: begin
            if (div_status.done) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = (bvalid_ff && step_big) ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      accept     = req_tvalid && (state_ff == ST_IDLE);
      mem_we     = (state_ff == ST_WRITE);
      div_start  = ((state_ff == ST_CHECK) && spread_ok)
                   || ((state_ff == ST_DIV_ACTIVE) && div_status.done);
      rsp_load   = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);
   end

   // Datapath next values
   always_comb begin
      wlen_in   = wlen_ff;
      band_in   = band_ff;
      mstep_in  = mstep_ff;
      fill_in   = fill_ff;
      oldest_in = oldest_ff;
      bvalid_in = bvalid_ff;
      base_a_in = base_a_ff;
      base_r_in = base_r_ff;
      samp_a_in = samp_a_ff;
      samp_r_in = samp_r_ff;
      rd_idx_in = rd_idx_ff;
      rdv_in    = 1'b0;
      mn_in     = mn_ff;
      mx_in     = mx_ff;
      sum_a_in  = sum_a_ff;
      sum_r_in  = sum_r_ff;
      lp_in     = lp_ff;
      lq_in     = lq_ff;
      step_in   = step_ff;
      dq_in     = dq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_da_in    = rsp_da_ff;
      rsp_dr_in    = rsp_dr_ff;
      rsp_on_in    = rsp_on_ff;
      rsp_lvl_in   = rsp_lvl_ff;

      // Capture the request
      if (accept) begin
         samp_a_in = req_tdata[SB-1:0];
         samp_r_in = req_tdata[2*SB-1:SB];
      end

      // Place the sample in the ring, prepare the scan
      if (state_ff == ST_WRITE) begin
         if (fill_short) begin
            fill_in = fill_ff + CW'(1);
         end else begin
            oldest_in = (oldest_inc == w_eff) ? '0 : oldest_inc[AW-1:0];
         end
         rd_idx_in = '0;
         mn_in     = {1'b0, {(SB-1){1'b1}}};
         mx_in     = {1'b1, {(SB-1){1'b0}}};
         sum_a_in  = '0;
         sum_r_in  = '0;
      end

      // Scan: issue one read a cycle, fold in the data of the previous one
      if (state_ff == ST_SCAN) begin
         if (rd_en) begin
            rd_idx_in = rd_idx_ff + CW'(1);
            rdv_in    = 1'b1;
         end
         if (rdv_ff) begin
            if ($signed(rd_active) < mn_ff) mn_in = $signed(rd_active);
            if ($signed(rd_active) > mx_ff) mx_in = $signed(rd_active);
            sum_a_in = sum_a_ff + {{(SW-SB){rd_active[SB-1]}}, rd_active};
            sum_r_in = sum_r_ff + {{(SW-SB){rd_reactive[SB-1]}}, rd_reactive};
         end
      end

      // Means out of the divider
      if ((state_ff == ST_DIV_ACTIVE) && div_status.done) begin
         lp_in = mean_full[SB-1:0];
      end
      if ((state_ff == ST_DIV_REACTIVE) && div_status.done) begin
         lq_in = mean_full[SB-1:0];
      end

      // Baseline follows every settled window
      if (state_ff == ST_DECIDE) begin
         step_in   = step_c;
         dq_in     = dq_c;
         bvalid_in = 1'b1;
         base_a_in = lp_ff;
         base_r_in = lq_ff;
      end

      // Response register
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_da_in    = step_ff;
         rsp_dr_in    = dq_ff;
         rsp_on_in    = !step_ff[SB];
         rsp_lvl_in   = lp_ff;
      end

      // Configuration write to a valid index clears window and baseline
      if (csr_we) begin
         case (csr_index)
            CSR_WINDOW_LENGTH: wlen_in  = csr_wdata[WLEN_BITS-1:0];
            CSR_STEADY_BAND:   band_in  = csr_wdata[BAND_BITS-1:0];
            CSR_MIN_STEP:      mstep_in = csr_wdata[BAND_BITS-1:0];
            default: ;
         endcase
         if ((csr_index == CSR_WINDOW_LENGTH) || (csr_index == CSR_STEADY_BAND)
             || (csr_index == CSR_MIN_STEP)) begin
            fill_in   = '0;
            oldest_in = '0;
            bvalid_in = 1'b0;
            base_a_in = '0;
            base_r_in = '0;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wlen_ff      <= RESET_WINDOW_LENGTH;
         band_ff      <= RESET_STEADY_BAND;
         mstep_ff     <= RESET_MIN_STEP;
         fill_ff      <= '0;
         oldest_ff    <= '0;
         bvalid_ff    <= 1'b0;
         base_a_ff    <= '0;
         base_r_ff    <= '0;
         rd_idx_ff    <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wlen_ff      <= wlen_in;
         band_ff      <= band_in;
         mstep_ff     <= mstep_in;
         fill_ff      <= fill_in;
         oldest_ff    <= oldest_in;
         bvalid_ff    <= bvalid_in;
         base_a_ff    <= base_a_in;
         base_r_ff    <= base_r_in;
         rd_idx_ff    <= rd_idx_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      samp_a_ff  <= samp_a_in;
      samp_r_ff  <= samp_r_in;
      mn_ff      <= mn_in;
      mx_ff      <= mx_in;
      sum_a_ff   <= sum_a_in;
      sum_r_ff   <= sum_r_in;
      lp_ff      <= lp_in;
      lq_ff      <= lq_in;
      step_ff    <= step_in;
      dq_ff      <= dq_in;
      rsp_da_ff  <= rsp_da_in;
      rsp_dr_ff  <= rsp_dr_in;
      rsp_on_ff  <= rsp_on_in;
      rsp_lvl_ff <= rsp_lvl_in;
   end

   // Sample ring
   psed_window_mem #(
      .DEPTH     (MAX_WINDOW),
      .DATA_BITS (SAMPLE_BITS)
   ) u_window_mem (
      .clock          (clock),
      .write_en       (mem_we),
      .write_addr     (slot),
      .write_active   (samp_a_ff),
      .write_reactive (samp_r_ff),
      .read_addr      (rd_idx_ff[AW-1:0]),
      .read_active    (rd_active),
      .read_reactive  (rd_reactive)
   );

   // Shared divider for both means
   psed_divider #(
      .DIVIDEND_BITS (SW),
      .DIVISOR_BITS  (CW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (w_eff),
      .quotient (div_quotient),
      .status   (div_status)
   );

   // Response ports
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = ODW'({rsp_lvl_ff, rsp_dr_ff, rsp_da_ff});
   assign rsp_tuser[0] = rsp_on_ff;

endmodule

### hdl/psed_window_mem.sv
// Sample window store: active and reactive rings, one write and one registered read port.
`timescale 1ns / 1ps

module psed_window_mem #(
   parameter int DEPTH     = psed_pkg::DEF_MAX_WINDOW,
   parameter int DATA_BITS = psed_pkg::DEF_SAMPLE_BITS
) (
   input  logic                       clock,
   input  logic                       write_en,
   input  logic [$clog2(DEPTH)-1:0]   write_addr,
   input  logic [DATA_BITS-1:0]       write_active,
   input  logic [DATA_BITS-1:0]       write_reactive,
   input  logic [$clog2(DEPTH)-1:0]   read_addr,
   output logic [DATA_BITS-1:0]       read_active,
   output logic [DATA_BITS-1:0]       read_reactive
);
   import psed_pkg::*;

   logic [DATA_BITS-1:0] active_mem_ff   [DEPTH];
   logic [DATA_BITS-1:0] reactive_mem_ff [DEPTH];
   logic [DATA_BITS-1:0] read_active_ff;
   logic [DATA_BITS-1:0] read_reactive_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (write_en) begin
         active_mem_ff[write_addr]   <= write_active;
         reactive_mem_ff[write_addr] <= write_reactive;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      read_active_ff   <= active_mem_ff[read_addr];
      read_reactive_ff <= reactive_mem_ff[read_addr];
   end

   assign read_active   = read_active_ff;
   assign read_reactive = read_reactive_ff;

endmodule

### hdl/psed_divider.sv
// Serial restoring divider, one quotient bit per cycle, shared by both means.
`timescale 1ns / 1ps

module psed_divider #(
   parameter int DIVIDEND_BITS = 30,
   parameter int DIVISOR_BITS  = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [DIVIDEND_BITS-1:0]      dividend,
   input  logic [DIVISOR_BITS-1:0]       divisor,
   output logic [DIVIDEND_BITS-1:0]      quotient,
   output psed_pkg::div_status_type      status
);
   import psed_pkg::*;

   localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [DIVISOR_BITS-1:0]  dsr_ff, dsr_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;

   logic [DIVISOR_BITS:0]    rem_shift;
   logic [DIVISOR_BITS+1:0]  trial;

   // One restoring step
   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
      trial     = {1'b0, rem_shift} - {2'b00, dsr_ff};
   end

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = CNT_BITS'(DIVIDEND_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[DIVISOR_BITS+1]) begin
            rem_in = rem_shift[DIVISOR_BITS-1:0];
            quo_in = {quo_ff[DIVIDEND_BITS-2:0], 1'b0};
         end else begin
            rem_in = trial[DIVISOR_BITS-1:0];
            quo_in = {quo_ff[DIVIDEND_BITS-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

### hdl/psed_checker.sv
// Port-level checker of the power step event detector, bound to the top level.
`timescale 1ns / 1ps
`include "power_step_event_detector_unit_defines.svh"

module psed_checker #(
   parameter int SAMPLE_BITS = psed_pkg::DEF_SAMPLE_BITS
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tvalid,
   input logic                                  req_tready,
   input logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    req_tdata,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [((3*SAMPLE_BITS+2+7)/8)*8-1:0]  rsp_tdata,
   input logic [0:0]                            rsp_tuser,
   input logic                                  csr_we,
   input logic [psed_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input logic [psed_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import psed_pkg::*;

   // Block goes busy right after taking a request
   `PSED_ASSERT(a_busy_after_req, (req_tvalid && req_tready) |=> !req_tready, "ready after request")

   // Stalled response holds
   `PSED_ASSERT(a_rsp_hold, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)), "stalled response changed")

   // A new response is loaded only from the busy sequencer
   `PSED_ASSERT(a_rsp_from_busy, $rose(rsp_tvalid) |-> !$past(req_tready), "response while idle")

   // Reset leaves the block ready and empty
   `PSED_ASSERT_ALWAYS(a_reset_state, $past(reset) |-> (req_tready && !rsp_tvalid), "bad state after reset")

endmodule

bind power_step_event_detector_unit psed_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_psed_checker (.*);

### sim/power_step_event_detector_unit_test.sv
// Self-checking testbench of the power step event detector: directed table, then random phases.
`timescale 1ns / 1ps

module power_step_event_detector_unit_test;
   import psed_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;  // no register behind it
   localparam int SETTLE_CYCLES  = 150;   // settle wait, past the longest request at W = 32
   localparam int LONG_HOLD      = 3000;  // response hold-off, long enough to back up the input
   localparam int TOTAL_REQUESTS = 1050;

   // One step event, as carried on the response channel
   typedef struct packed {
      logic signed [24:0] delta_active;
      logic signed [24:0] delta_reactive;
      logic               turn_on;
      logic signed [23:0] new_level;
   } step_event_t;

   // Directed table rows: a register write, or a request whose outcome is
   // either predicted or typed in (no event / this event)
   typedef enum logic [1:0] {ROW_WRITE, ROW_CHECKED, ROW_QUIET, ROW_EVENT} row_kind_t;

   typedef struct packed {
      row_kind_t                 kind;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CSR_DATA_BITS-1:0]  value;
      logic signed [23:0]        active;
      logic signed [23:0]        reactive;
      step_event_t               ev;
   } stim_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // active_power [23:0], reactive_power [47:24]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;        // delta_active [24:0], delta_reactive [49:25], new_level [73:50]
   logic [0:0]  rsp_tuser;        // turn_on [0]
   logic        csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_WINDOW_LENGTH;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   power_step_event_detector_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Bookkeeping shared by the request and response sides
   step_event_t pending_events [$];
   int          failure_count   = 0;
   int          events_checked  = 0;
   int          items_sent      = 0;
   int          settings_written = 0;
   int          req_idle_pct    = 36;
   int          rsp_idle_pct    = 85;
   bit          hold_request    = 1'b0;

   // Predictor state: registers, sample ring and baseline
   logic [WLEN_BITS-1:0] cfg_wlen = RESET_WINDOW_LENGTH;
   logic [BAND_BITS-1:0] cfg_band = RESET_STEADY_BAND;
   logic [BAND_BITS-1:0] cfg_min  = RESET_MIN_STEP;
   logic signed [23:0]   ring_active [32];
   logic signed [23:0]   ring_reactive [32];
   int unsigned          fill = 0;
   int unsigned          oldest = 0;
   bit                   base_valid = 1'b0;
   longint               base_active = 0;
   longint               base_reactive = 0;

   function automatic string fmt_event(step_event_t e);
      return $sformatf("da=%0d dr=%0d on=%0b level=%0d",
                       e.delta_active, e.delta_reactive, e.turn_on, e.new_level);
   endfunction

   function automatic void note_failure(string what);
      failure_count++;
      if (failure_count <= 10) begin
         $display("%0t ns: %s", $time, what);
      end
   endfunction

   // Zero means 1, anything past the ring size means the whole ring
   function automatic int unsigned window_size();
      if (cfg_wlen == 0) begin
         return 1;
      end
      if (cfg_wlen > 32) begin
         return 32;
      end
      return cfg_wlen;
   endfunction

   // Round to nearest, ties away from zero
   function automatic longint rounded_mean(longint sum, int unsigned w);
      longint div, half;
      div = longint'(w);
      half = div / 2;
      if (sum >= 0) begin
         return (sum + half) / div;
      end
      return -((-sum + half) / div);
   endfunction

   function automatic logic signed [23:0] clamp_sample(longint v);
      if (v > 8388607) begin
         return 24'sh7FFFFF;
      end
      if (v < -8388608) begin
         return 24'sh800000;
      end
      return v[23:0];
   endfunction

   function automatic longint jitter(int unsigned half);
      return longint'($urandom_range(2 * half)) - longint'(half);
   endfunction

   // Register write as the block sees it; a valid index restarts detection
   task automatic apply_setting(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] value);
      case (idx)
         CSR_WINDOW_LENGTH: cfg_wlen = value[WLEN_BITS-1:0];
         CSR_STEADY_BAND:   cfg_band = value;
         CSR_MIN_STEP:      cfg_min  = value;
         default:           return;
      endcase
      fill = 0;
      oldest = 0;
      base_valid = 1'b0;
      base_active = 0;
      base_reactive = 0;
   endtask

   // Ring update, settle test, rounded means and step decision for one request
   task automatic track_power_sample(input logic signed [23:0] p, input logic signed [23:0] q,
                                     output bit fired, output step_event_t ev);
      int unsigned w, s, i;
      longint mn, mx, sp, sq, lp, lq, dp, dq, mag;
      w = window_size();
      fired = 1'b0;
      ev = '0;
      if (fill < w) begin
         ring_active[fill] = p;
         ring_reactive[fill] = q;
         fill++;
      end else begin
         s = oldest % w;
         ring_active[s] = p;
         ring_reactive[s] = q;
         oldest = (s + 1) % w;
      end
      if (fill < w) begin
         return;
      end
      mn = ring_active[0];
      mx = ring_active[0];
      sp = 0;
      sq = 0;
      for (i = 0; i < w; i++) begin
         if (ring_active[i] < mn) mn = ring_active[i];
         if (ring_active[i] > mx) mx = ring_active[i];
         sp += ring_active[i];
         sq += ring_reactive[i];
      end
      if (mx - mn > longint'(cfg_band)) begin
         return;
      end
      lp = rounded_mean(sp, w);
      lq = rounded_mean(sq, w);
      if (!base_valid) begin
         base_valid = 1'b1;
         base_active = lp;
         base_reactive = lq;
         return;
      end
      dp = lp - base_active;
      dq = lq - base_reactive;
      mag = (dp < 0) ? -dp : dp;
      if (mag > longint'(cfg_min)) begin
         fired = 1'b1;
         ev.delta_active = dp[24:0];
         ev.delta_reactive = dq[24:0];
         ev.turn_on = (dp > 0);
         ev.new_level = lp[23:0];
      end
      base_active = lp;
      base_reactive = lq;
   endtask

   function automatic stim_row_t sample_row(row_kind_t kind, int p, int q, int da = 0,
                                            int dr = 0, int on = 0, int lvl = 0);
      stim_row_t r;
      r = '0;
      r.kind = kind;
      r.active = p[23:0];
      r.reactive = q[23:0];
      r.ev.delta_active = da[24:0];
      r.ev.delta_reactive = dr[24:0];
      r.ev.turn_on = on[0];
      r.ev.new_level = lvl[23:0];
      return r;
   endfunction

   function automatic stim_row_t setting_row(logic [CSR_INDEX_BITS-1:0] idx, int value);
      stim_row_t r;
      r = '0;
      r.kind = ROW_WRITE;
      r.index = idx;
      r.value = value[CSR_DATA_BITS-1:0];
      return r;
   endfunction

   // Offer one request after a random gap; record its outcome once taken
   task automatic push_request(logic signed [23:0] p, logic signed [23:0] q,
                               row_kind_t kind = ROW_CHECKED, step_event_t typed_ev = '0);
      bit fired;
      step_event_t ev;
      if (items_sent < 360) begin
         req_idle_pct = 36;
         rsp_idle_pct = 85;
      end else if (items_sent < 720) begin
         req_idle_pct = 85;
         rsp_idle_pct = 36;
      end else begin
         req_idle_pct = 0;
         rsp_idle_pct = 0;
      end
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {q, p};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      track_power_sample(p, q, fired, ev);
      if (kind == ROW_EVENT) begin
         pending_events.push_back(typed_ev);
      end else if (kind == ROW_CHECKED && fired) begin
         pending_events.push_back(ev);
      end
   endtask

   // Drop valid, wait for every expected event, then let the block go idle
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_setting(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      apply_setting(idx, value);
      settings_written++;
      @(posedge clock);
   endtask

   // Window, band and step settings, then steady segments with steps, noise bursts and short segments
   task automatic run_phase(logic [WLEN_BITS-1:0] wlen, logic [BAND_BITS-1:0] band,
                            logic [BAND_BITS-1:0] min_step, int budget, bit hold_off);
      int unsigned w, nh, span, mag, seg_len, pick, j, raw_a, raw_r;
      longint cur_a, cur_r;
      int start;
      settle_block();
      raw_a = $urandom();
      write_setting(CSR_WINDOW_LENGTH, {raw_a[16:0], wlen});
      write_setting(CSR_STEADY_BAND, band);
      write_setting(CSR_MIN_STEP, min_step);
      if ($urandom_range(1) == 1) begin
         raw_r = $urandom();
         write_setting(CSR_UNUSED, raw_r[CSR_DATA_BITS-1:0]);
      end
      if (hold_off) begin
         hold_request = 1'b1;
      end
      w = window_size();
      span = 2 * cfg_min + 8;
      cur_a = jitter(200000);
      cur_r = jitter(200000);
      start = items_sent;
      while (items_sent - start < budget) begin
         pick = $urandom_range(99);
         nh = (cfg_band > 131070) ? 65535 : cfg_band / 2;
         if (pick < 78) begin
            // steady segment at a new level, now and then too noisy to settle
            if ($urandom_range(3) == 0) begin
               cur_a = longint'($urandom_range(16777215)) - 8388608;
            end else begin
               mag = $urandom_range(span);
               cur_a = ($urandom_range(1) == 1) ? cur_a + mag : cur_a - mag;
            end
            cur_a = clamp_sample(cur_a);
            cur_r = clamp_sample(cur_r + jitter(10000));
            if ($urandom_range(9) == 0) begin
               nh = nh * 3 + 4;
            end
            seg_len = w + $urandom_range(w + 3);
         end else if (pick < 90) begin
            // raw noise over the whole field range
            seg_len = $urandom_range(1, 6);
            for (j = 0; j < seg_len; j++) begin
               raw_a = $urandom();
               raw_r = $urandom();
               push_request(raw_a[23:0], raw_r[23:0]);
            end
            seg_len = 0;
         end else begin
            // segment cut short before the window fills
            cur_a = longint'($urandom_range(16777215)) - 8388608;
            seg_len = $urandom_range(1, (w > 1) ? w - 1 : 1);
         end
         for (j = 0; j < seg_len; j++) begin
            push_request(clamp_sample(cur_a + jitter(nh)), clamp_sample(cur_r + jitter(nh)));
         end
      end
   endtask

   // Response side: check each event, stall at random, hold off on request
   initial begin : response_side
      step_event_t got, want;
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.delta_active = rsp_tdata[24:0];
            got.delta_reactive = rsp_tdata[49:25];
            got.turn_on = rsp_tuser[0];
            got.new_level = rsp_tdata[73:50];
            if (pending_events.size() == 0) begin
               note_failure({"step event with nothing pending: ", fmt_event(got)});
            end else begin
               want = pending_events.pop_front();
               events_checked++;
               if (got !== want) begin
                  note_failure({"step event mismatch: expected ", fmt_event(want),
                                ", got ", fmt_event(got)});
               end
            end
         end
         if (hold_request) begin
            hold_left = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Stimulus: directed table, fixed phases at the extremes, random phases
   initial begin : request_side
      stim_row_t directed_rows [$];
      int unsigned rw, rb, rm;
      directed_rows = '{
         // defaults after reset: fill, baseline, then a clean turn-on step
         sample_row(ROW_QUIET, 0, 0),
         sample_row(ROW_QUIET, 0, 0),
         sample_row(ROW_QUIET, 0, 0),
         sample_row(ROW_QUIET, 0, 0),
         sample_row(ROW_QUIET, 1600, 320),
         sample_row(ROW_QUIET, 1600, 320),
         sample_row(ROW_QUIET, 1600, 320),
         sample_row(ROW_EVENT, 1600, 320, 1600, 320, 1, 1600),
         // single-sample window, widest band, any step counts
         setting_row(CSR_WINDOW_LENGTH, 1),
         setting_row(CSR_STEADY_BAND, 8388607),
         setting_row(CSR_MIN_STEP, 0),
         sample_row(ROW_QUIET, 8388607, -8388608),
         sample_row(ROW_EVENT, -8388608, 8388607, -16777215, 16777215, 0, -8388608),
         sample_row(ROW_EVENT, 8388607, -8388608, 16777215, -16777215, 1, 8388607),
         sample_row(ROW_QUIET, 8388607, 0),
         sample_row(ROW_EVENT, 8388606, 5, -1, 5, 0, 8388606),
         // step exactly at the threshold stays quiet
         setting_row(CSR_MIN_STEP, 10),
         sample_row(ROW_QUIET, 0, 0),
         sample_row(ROW_QUIET, 10, 0),
         sample_row(ROW_EVENT, 21, 3, 11, 3, 1, 21),
         // zero window length acts as one
         setting_row(CSR_WINDOW_LENGTH, 0),
         sample_row(ROW_QUIET, 100, 7),
         sample_row(ROW_EVENT, -100, -7, -200, -14, 0, -100),
         // rounding ties, and a write to no register keeps the window
         setting_row(CSR_WINDOW_LENGTH, 2),
         sample_row(ROW_CHECKED, 1, 1),
         sample_row(ROW_CHECKED, 2, -2),
         sample_row(ROW_CHECKED, -3, -3),
         setting_row(CSR_UNUSED, 0),
         sample_row(ROW_CHECKED, -40, -3)
      };
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_WRITE) begin
            settle_block();
            write_setting(directed_rows[r].index, directed_rows[r].value);
         end else begin
            push_request(directed_rows[r].active, directed_rows[r].reactive,
                         directed_rows[r].kind, directed_rows[r].ev);
         end
      end
      run_phase(6'd4, 23'd320, 23'd480, 90, 1'b0);
      run_phase(6'd1, 23'h7FFFFF, 23'd0, 80, 1'b1);
      run_phase(6'd32, 23'd400, 23'd300, 150, 1'b0);
      run_phase(6'd63, 23'd1000, 23'd800, 90, 1'b0);
      run_phase(6'd0, 23'd0, 23'd0, 60, 1'b0);
      run_phase(6'd2, 23'd0, 23'h7FFFFF, 50, 1'b0);
      while (items_sent < TOTAL_REQUESTS) begin
         rw = $urandom_range(1, 12);
         rb = $urandom_range(3000);
         rm = $urandom_range(3000);
         run_phase(rw[WLEN_BITS-1:0], rb[BAND_BITS-1:0], rm[BAND_BITS-1:0], 100, 1'b0);
      end
      settle_block();
      $display("Covered %0d requests and %0d register writes; %0d step events checked.",
               items_sent, settings_written, events_checked);
      $display("Window lengths 0 to 63, band and step extremes, output hold-off with stalls.");
      if (failure_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d failures", failure_count);
         $display("TEST FAILED");
      end
      $finish;
   end

   // Hard stop well past the slowest legal run
   initial begin : watchdog
      #20_000_000;
      $display("Timeout with %0d step events still pending", pending_events.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule
